// File: rtl/spq_pkg.sv
package spq_pkg;

    localparam int FUNC_W = 3;
    localparam int OUT_W  = 32;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_INSERT = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FUNC_SORT   = FUNC_W'(4);

    typedef struct packed {
        logic apply;
        logic sort_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic sort_done;
    } t_dp_stat;

endpackage

// File: rtl/spq_if.sv
interface spq_in_if #(
    parameter int KEY_WIDTH = 32
);
    logic                       valid;
    logic                       ready;
    logic [spq_pkg::FUNC_W-1:0] func;
    logic [KEY_WIDTH-1:0]       key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

interface spq_out_if #(
    parameter int CNT_W = 5
);
    logic                      valid;
    logic                      ready;
    logic [spq_pkg::OUT_W-1:0] head_value;
    logic [spq_pkg::OUT_W-1:0] tail_value;
    logic [CNT_W-1:0]          count;
    logic                      is_ascending;
    logic                      overflow;
    logic                      underflow;

    modport source (output valid, output head_value, output tail_value, output count,
                    output is_ascending, output overflow, output underflow, input ready);
    modport sink   (input valid, input head_value, input tail_value, input count,
                    input is_ascending, input overflow, input underflow, output ready);
endinterface

// File: rtl/sorted_insert_priority_queue_unit.sv
// Append, sorted insert, remove, clear and no-op: the transaction is applied when accepted
// and the report state then loads the result registers; a new transaction is taken only
// once the controller is back in idle. Sort: the sort state moves one entry out of the
// unsorted part per cycle through the row of compare cells, then the report state loads
// the result, and no new transaction is taken before that.
// Reset clears the fill count and valid flags; stored keys are not cleared.
module sorted_insert_priority_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_cmd,
    spq_out_if.source o_rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;
    logic     out_valid;

    assign i_cmd.ready = in_ready;
    assign o_rsp.valid = out_valid;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .i_func      (i_cmd.func),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    spq_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_func         (i_cmd.func),
        .i_key          (i_cmd.key),
        .o_head_value   (o_rsp.head_value),
        .o_tail_value   (o_rsp.tail_value),
        .o_count        (o_rsp.count),
        .o_is_ascending (o_rsp.is_ascending),
        .o_overflow     (o_rsp.overflow),
        .o_underflow    (o_rsp.underflow)
    );

endmodule

// File: rtl/spq_ctrl.sv
module spq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [spq_pkg::FUNC_W-1:0]   i_func,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output spq_pkg::t_dp_cmd             o_cmd,
    input  spq_pkg::t_dp_stat            i_stat
);
    import spq_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SORT   = 2'd1;
    localparam logic [1:0] ST_REPORT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;

    // The result register is free when empty or being emptied in this cycle.
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd.apply     = 1'b0;
        o_cmd.sort_step = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.apply = 1'b1;
                    n_state     = (i_func == FUNC_SORT) ? ST_SORT : ST_REPORT;
                end
            end
            ST_SORT: begin
                if (i_stat.sort_done) begin
                    n_state = ST_REPORT;
                end else begin
                    o_cmd.sort_step = 1'b1;
                end
            end
            ST_REPORT: begin
                o_cmd.load_out = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/spq_dp.sv
module spq_dp #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spq_pkg::t_dp_cmd           i_cmd,
    output spq_pkg::t_dp_stat          o_stat,
    input  logic [spq_pkg::FUNC_W-1:0] i_func,
    input  logic [KEY_WIDTH-1:0]       i_key,
    output logic [spq_pkg::OUT_W-1:0]  o_head_value,
    output logic [spq_pkg::OUT_W-1:0]  o_tail_value,
    output logic [CNT_W-1:0]           o_count,
    output logic                       o_is_ascending,
    output logic                       o_overflow,
    output logic                       o_underflow
);
    import spq_pkg::*;

    logic [KEY_WIDTH-1:0] r_e [DEPTH];
    logic [KEY_WIDTH-1:0] n_e [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    logic [DEPTH-1:0]     n_valid;
    logic [DEPTH-1:0]     r_uns;
    logic [DEPTH-1:0]     n_uns;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [KEY_WIDTH-1:0] r_tail;
    logic [KEY_WIDTH-1:0] n_tail;
    logic                 r_ovf;
    logic                 n_ovf;
    logic                 r_unf;
    logic                 n_unf;

    logic                 full;
    logic                 empty;
    logic                 do_append;
    logic                 do_insert;
    logic                 do_remove;
    logic                 do_clear;
    logic                 do_sort;
    logic [KEY_WIDTH-1:0] u0;

    logic [DEPTH-1:0]     ge;
    logic [DEPTH-1:0]     sge;
    logic [DEPTH-1:0]     first_free;
    logic [DEPTH-1:0]     take_next;
    logic [DEPTH-1:0]     take_prev;
    logic [DEPTH:0]       nge_from;
    logic [DEPTH-2:0]     desc;

    assign full      = r_valid[DEPTH-1];
    assign empty     = !r_valid[0];
    assign do_append = i_cmd.apply && (i_func == FUNC_APPEND) && !full;
    assign do_insert = i_cmd.apply && (i_func == FUNC_INSERT) && !full;
    assign do_remove = i_cmd.apply && (i_func == FUNC_REMOVE) && !empty;
    assign do_clear  = i_cmd.apply && (i_func == FUNC_CLEAR);
    assign do_sort   = i_cmd.apply && (i_func == FUNC_SORT);
    assign u0        = r_e[0];

    assign o_stat.sort_done = ~|r_uns;

    // nge_from[i] is set when no stored entry at or beyond slot i is at least the key.
    genvar gj;
    generate
        for (gj = 0; gj <= DEPTH; gj++) begin : g_nge
            assign nge_from[gj] = ~|(ge >> gj);
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [KEY_WIDTH-1:0] prev_e;
            logic [KEY_WIDTH-1:0] next_e;
            logic                 inrange;
            logic                 shift_in;
            logic                 place;

            assign ge[gi]  = r_valid[gi] && (r_e[gi] >= i_key);
            assign sge[gi] = r_valid[gi] && !r_uns[gi] && (r_e[gi] >= u0);

            if (gi == 0) begin : g_first
                assign first_free[gi] = !r_valid[gi];
                assign take_prev[gi]  = 1'b1;
                assign prev_e         = r_e[gi];
                assign shift_in       = 1'b0;
                assign place          = inrange && nge_from[gi];
            end else begin : g_rest
                assign first_free[gi] = !r_valid[gi] && r_valid[gi-1];
                assign take_prev[gi]  = take_next[gi-1];
                assign prev_e         = r_e[gi-1];
                assign shift_in       = inrange && nge_from[gi-1];
                assign place          = inrange && nge_from[gi] && !nge_from[gi-1];
            end

            if (gi < DEPTH - 1) begin : g_mid
                assign take_next[gi] = r_uns[gi+1] || sge[gi+1];
                assign next_e        = r_e[gi+1];
            end else begin : g_last
                assign take_next[gi] = 1'b0;
                assign next_e        = r_e[gi];
            end

            assign inrange = r_valid[gi] || first_free[gi];

            always_comb begin
                n_e[gi] = r_e[gi];
                if (do_append && first_free[gi]) begin
                    n_e[gi] = i_key;
                end else if (do_insert && shift_in) begin
                    n_e[gi] = prev_e;
                end else if (do_insert && place) begin
                    n_e[gi] = i_key;
                end else if (do_remove) begin
                    n_e[gi] = next_e;
                end else if (i_cmd.sort_step) begin
                    // The head leaves the unsorted part and drops in behind every
                    // sorted entry that is at least as large.
                    if (take_next[gi]) begin
                        n_e[gi] = next_e;
                    end else if (take_prev[gi]) begin
                        n_e[gi] = u0;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_e[gi] <= n_e[gi];
            end
        end

        for (gi = 0; gi < DEPTH - 1; gi++) begin : g_pair
            assign desc[gi] = r_valid[gi+1] && (r_e[gi+1] < r_e[gi]);
        end
    endgenerate

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        n_uns   = r_uns;
        n_tail  = r_tail;
        n_ovf   = r_ovf;
        n_unf   = r_unf;
        if (i_cmd.apply) begin
            n_ovf = ((i_func == FUNC_APPEND) || (i_func == FUNC_INSERT)) && full;
            n_unf = (i_func == FUNC_REMOVE) && empty;
        end
        if (do_append || do_insert) begin
            n_valid = {r_valid[DEPTH-2:0], 1'b1};
            n_count = r_count + CNT_W'(1);
        end
        if (do_append || (do_insert && (empty || (r_tail >= i_key)))) begin
            n_tail = i_key;
        end
        if (do_remove) begin
            n_valid = r_valid >> 1;
            n_count = r_count - CNT_W'(1);
        end
        if (do_clear) begin
            n_valid = '0;
            n_count = '0;
        end
        if (do_sort) begin
            n_uns = r_valid;
        end
        if (i_cmd.sort_step) begin
            n_uns = r_uns >> 1;
            if ((r_uns == r_valid) || (r_tail >= u0)) begin
                n_tail = u0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_uns   <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_uns   <= n_uns;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail <= n_tail;
        r_ovf  <= n_ovf;
        r_unf  <= n_unf;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_head_value   <= empty ? '0 : OUT_W'(r_e[0]);
            o_tail_value   <= empty ? '0 : OUT_W'(r_tail);
            o_count        <= r_count;
            o_is_ascending <= ~|desc;
            o_overflow     <= r_ovf;
            o_underflow    <= r_unf;
        end
    end

endmodule

// File: tb/sv/spq_status_checker.sv
module spq_status_checker #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_in_if    i_cmd,
    spq_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_outstanding
);
    import spq_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] head;
        logic [OUT_W-1:0] tail;
        logic [CNT_W-1:0] count;
        logic             ascending;
        logic             overflow;
        logic             underflow;
    } t_queue_status;

    logic [KEY_WIDTH-1:0] slots [DEPTH];
    int                   fill = 0;
    t_queue_status        expected_status_q [$];
    t_queue_status        want;
    int                   errors = 0;
    int                   n_results = 0;

    assign o_fail_count = errors;

    // Applies one command to the local copy of the queue and returns the status it leaves.
    function automatic t_queue_status queue_after_command(logic [FUNC_W-1:0] func,
                                                          logic [KEY_WIDTH-1:0] key);
        t_queue_status        st;
        int                   pos;
        logic [KEY_WIDTH-1:0] held;
        st = '0;
        case (func)
            FUNC_APPEND, FUNC_INSERT: begin
                if (fill >= DEPTH) begin
                    st.overflow = 1'b1;
                end else begin
                    pos = fill;
                    // A sorted insert lands after any keys equal to it.
                    if (func == FUNC_INSERT) begin
                        while (pos > 0 && slots[pos-1] < key) begin
                            slots[pos] = slots[pos-1];
                            pos--;
                        end
                    end
                    slots[pos] = key;
                    fill++;
                end
            end
            FUNC_REMOVE: begin
                if (fill == 0) begin
                    st.underflow = 1'b1;
                end else begin
                    for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
                    fill--;
                end
            end
            FUNC_CLEAR: begin
                fill = 0;
            end
            FUNC_SORT: begin
                for (int i = 1; i < fill; i++) begin
                    held = slots[i];
                    pos  = i;
                    while (pos > 0 && slots[pos-1] < held) begin
                        slots[pos] = slots[pos-1];
                        pos--;
                    end
                    slots[pos] = held;
                end
            end
            default: begin
            end
        endcase
        if (fill > 0) begin
            st.head = OUT_W'(slots[0]);
            st.tail = OUT_W'(slots[fill-1]);
        end
        st.count     = CNT_W'(fill);
        st.ascending = 1'b1;
        for (int i = 1; i < fill; i++) begin
            if (slots[i] < slots[i-1]) st.ascending = 1'b0;
        end
        return st;
    endfunction

    task automatic report_mismatch(string field, logic [OUT_W-1:0] got, logic [OUT_W-1:0] exp_val);
        $display("ERROR result %0d: %s is 0x%0h, predicted 0x%0h",
                 n_results, field, got, exp_val);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_status_q.size() == 0) begin
                    report_mismatch("unexpected result, head_value", i_rsp.head_value, '0);
                end else begin
                    want = expected_status_q.pop_front();
                    if (i_rsp.head_value !== want.head)
                        report_mismatch("head_value", i_rsp.head_value, want.head);
                    if (i_rsp.tail_value !== want.tail)
                        report_mismatch("tail_value", i_rsp.tail_value, want.tail);
                    if (i_rsp.count !== want.count)
                        report_mismatch("count", OUT_W'(i_rsp.count), OUT_W'(want.count));
                    if (i_rsp.is_ascending !== want.ascending)
                        report_mismatch("is_ascending", OUT_W'(i_rsp.is_ascending),
                                        OUT_W'(want.ascending));
                    if (i_rsp.overflow !== want.overflow)
                        report_mismatch("overflow", OUT_W'(i_rsp.overflow),
                                        OUT_W'(want.overflow));
                    if (i_rsp.underflow !== want.underflow)
                        report_mismatch("underflow", OUT_W'(i_rsp.underflow),
                                        OUT_W'(want.underflow));
                end
                n_results++;
            end
            // The result of a transaction never appears in the cycle it is taken, so the
            // compare above can safely run first.
            if (i_cmd.valid && i_cmd.ready) begin
                expected_status_q.push_back(queue_after_command(i_cmd.func, i_cmd.key));
            end
        end
        o_outstanding <= expected_status_q.size();
    end

endmodule

// File: tb/sv/tb_sorted_insert_priority_queue_unit.sv
module tb_sorted_insert_priority_queue_unit;
    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int CNT_W       = 5;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 215;
    localparam int FLOOD_ITEMS = 60;
    localparam logic [FUNC_W-1:0] FUNC_LAST = '1;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} t_mix;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct = 0;
    int   stall_pct;
    logic hold_req;
    bit   hold_done = 1'b0;
    int   idle_cycles = 0;
    int   fail_count;
    int   outstanding;

    spq_in_if  #(.KEY_WIDTH(KEY_WIDTH)) cmd_if ();
    spq_out_if #(.CNT_W(CNT_W))         rsp_if ();

    sorted_insert_priority_queue_unit #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    spq_status_checker #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd         (cmd_if),
        .i_rsp         (rsp_if),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls, and once a long hold-off so that the queue backs up.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_item(logic [FUNC_W-1:0] func, logic [KEY_WIDTH-1:0] key);
        while ($urandom_range(99) < idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.func  <= func;
        cmd_if.key   <= key;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    function automatic logic [FUNC_W-1:0] spare_func();
        return FUNC_W'(FUNC_SORT + 1 + $urandom_range(FUNC_LAST - FUNC_SORT - 1));
    endfunction

    // Small keys give plenty of duplicates, which exercise the ordering of equal entries.
    function automatic logic [KEY_WIDTH-1:0] pick_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KEY_WIDTH'($urandom_range(7));
            5:       return {1'b1, {KEY_WIDTH-1{1'b0}}} | KEY_WIDTH'($urandom_range(3));
            default: return KEY_WIDTH'($urandom());
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(t_mix mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_GROW: begin
                if (r < 45) return FUNC_APPEND;
                if (r < 85) return FUNC_INSERT;
                if (r < 93) return FUNC_REMOVE;
                if (r < 96) return FUNC_SORT;
                if (r < 98) return spare_func();
                return FUNC_CLEAR;
            end
            MIX_SHRINK: begin
                if (r < 15) return FUNC_APPEND;
                if (r < 30) return FUNC_INSERT;
                if (r < 85) return FUNC_REMOVE;
                if (r < 92) return FUNC_SORT;
                if (r < 95) return spare_func();
                return FUNC_CLEAR;
            end
            default: begin
                if (r < 25) return FUNC_APPEND;
                if (r < 50) return FUNC_INSERT;
                if (r < 80) return FUNC_REMOVE;
                if (r < 90) return FUNC_SORT;
                if (r < 95) return spare_func();
                return FUNC_CLEAR;
            end
        endcase
    endfunction

    task automatic run_phase(int n_items, int sender_idle, int receiver_stall);
        t_mix mix;
        mix       = MIX_EVEN;
        idle_pct  = sender_idle;
        stall_pct <= receiver_stall;
        for (int i = 0; i < n_items; i++) begin
            // Bursts of growth and shrinkage carry the queue between empty and full.
            if (i % 24 == 0) mix = t_mix'($urandom_range(2));
            send_item(pick_func(mix), pick_key());
        end
        wait_drained();
    endtask

    initial begin
        rst_n        <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.func  <= FUNC_APPEND;
        cmd_if.key   <= '0;
        stall_pct    <= 0;
        hold_req     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: removal underflows, and sort and the spare codes leave it empty.
        send_item(FUNC_REMOVE, '1);
        send_item(FUNC_SORT, '1);
        for (int f = FUNC_SORT + 1; f <= FUNC_LAST; f++) send_item(FUNC_W'(f), pick_key());
        send_item(FUNC_APPEND, '0);
        send_item(FUNC_APPEND, '1);
        send_item(FUNC_INSERT, {1'b1, {KEY_WIDTH-1{1'b0}}});
        send_item(FUNC_INSERT, {1'b1, {KEY_WIDTH-1{1'b0}}});
        send_item(FUNC_SORT, '0);
        send_item(FUNC_REMOVE, '0);
        send_item(FUNC_CLEAR, '1);
        // Fill to the brim in ascending order, then push into a full queue both ways.
        for (int i = 0; i < DEPTH; i++) send_item(FUNC_APPEND, KEY_WIDTH'(i * 3));
        send_item(FUNC_APPEND, '1);
        send_item(FUNC_INSERT, '1);
        send_item(FUNC_SORT, '0);
        send_item(FUNC_REMOVE, '0);
        wait_drained();

        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 53, 0);
        run_phase(PHASE_ITEMS, 0, 53);
        run_phase(PHASE_ITEMS, 13, 13);

        // Sender keeps offering while the receiver holds off, so the input must stall.
        idle_pct  = 0;
        stall_pct <= 0;
        hold_req  <= 1'b1;
        for (int i = 0; i < FLOOD_ITEMS; i++) send_item(pick_func(MIX_EVEN), pick_key());
        wait_drained();

        repeat (40) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/sorted_insert_priority_queue_unit.sv
tb/sv/spq_status_checker.sv
tb/sv/tb_sorted_insert_priority_queue_unit.sv
